/* hw/rtl/rsge_pkg.sv */
`default_nettype none
package rsge_pkg;

  localparam int unsigned NumDigits  = 13;
  localparam int unsigned NumParity  = 4;
  localparam int unsigned NumSymbols = NumDigits + NumParity;
  localparam int unsigned NumChars   = 20;
  localparam int unsigned SymW       = 5;
  localparam int unsigned CharW      = 7;
  localparam int unsigned AcctW      = 64;

  // field polynomial x^5+x^2+1
  localparam logic [5:0] GfPoly = 6'h25;

  // generator taps
  localparam logic [SymW-1:0] Tap0 = 5'd17;
  localparam logic [SymW-1:0] Tap1 = 5'd9;
  localparam logic [SymW-1:0] Tap2 = 5'd6;
  localparam logic [SymW-1:0] Tap3 = 5'd30;

  localparam logic [CharW-1:0] DashCode = 7'd45;

  // alphabet, first character in the top byte
  localparam logic [32*8-1:0] Alphabet = "23456789ABCDEFGHJKLMNPQRSTUVWXYZ";

  // codeword symbol shown at each character position (dash positions unused)
  localparam logic [SymW-1:0] CharSym [NumChars] = '{
    5'd3, 5'd2, 5'd1, 5'd0, 5'd0,
    5'd7, 5'd6, 5'd5, 5'd4, 5'd0,
    5'd13, 5'd14, 5'd15, 5'd16, 5'd0,
    5'd12, 5'd8, 5'd9, 5'd10, 5'd11
  };

  // character positions that carry a dash (positions 4, 9 and 14)
  localparam logic [NumChars-1:0] CharIsDash = 20'h04210;

  typedef struct packed {
    logic [NumSymbols-1:0][SymW-1:0] sym;
  } codeword_t;

  // multiply two GF(32) elements modulo the field polynomial
  function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] x,
                                             input logic [SymW-1:0] y);
    logic [8:0] acc;
    acc = '0;
    for (int b = 0; b < 5; b++) begin
      if (y[b]) acc = acc ^ (9'(x) << b);
    end
    for (int b = 8; b >= 5; b--) begin
      if (acc[b]) acc = acc ^ (9'(GfPoly) << (b - 5));
    end
    return acc[SymW-1:0];
  endfunction

  // map a symbol to its ASCII character
  function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] s);
    logic [7:0] c;
    c = Alphabet[(8'd31 - 8'(s)) * 8 +: 8];
    return c[CharW-1:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rsge_front.sv */
`default_nettype none
module rsge_front
  import rsge_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [AcctW-1:0] account_id_i,
  output logic                  push_o,
  output codeword_t             push_data_o,
  input  wire logic             full_i
);

  logic             busy_q, busy_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [AcctW-1:0] acct_q, acct_d;
  logic [NumParity-1:0][SymW-1:0] par_q, par_d, par_n;
  logic [AcctW:0]   acct_ext;
  logic [NumDigits-1:0][SymW-1:0] digits;
  logic [SymW-1:0]  digit;
  logic [SymW-1:0]  fb;
  logic             last_step;
  logic             accept;

  // split the account into base-32 digits, least significant first
  assign acct_ext = {1'b0, acct_q};
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      digits[i] = acct_ext[i*SymW +: SymW];
    end
  end

  // pick the digit for this step, top digit first
  always_comb begin
    digit = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (cnt_q == 4'(i)) digit = digits[i];
    end
  end

  // one LFSR step
  assign fb       = digit ^ par_q[3];
  assign par_n[3] = par_q[2] ^ gf_mul(Tap3, fb);
  assign par_n[2] = par_q[1] ^ gf_mul(Tap2, fb);
  assign par_n[1] = par_q[0] ^ gf_mul(Tap1, fb);
  assign par_n[0] = gf_mul(Tap0, fb);

  assign last_step  = (cnt_q == 4'd0);
  assign push_o     = busy_q && last_step && !full_i;
  assign in_stall_o = busy_q && !push_o;
  assign accept     = in_valid_i && !in_stall_o;

  // assemble the codeword: digits, then parity
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      push_data_o.sym[i] = digits[i];
    end
    for (int j = 0; j < NumParity; j++) begin
      push_data_o.sym[NumDigits + j] = par_n[j];
    end
  end

  // load a new word, advance the LFSR, or hold while the queue is full
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acct_d = acct_q;
    par_d  = par_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = 4'(NumDigits - 1);
      acct_d = account_id_i;
      par_d  = '0;
    end else if (push_o) begin
      busy_d = 1'b0;
    end else if (busy_q && !last_step) begin
      cnt_d = cnt_q - 4'd1;
      par_d = par_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acct_q <= acct_d;
    par_q  <= par_d;
  end

endmodule
`default_nettype wire

/* hw/rtl/rsge_fifo.sv */
`default_nettype none
module rsge_fifo
  import rsge_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire codeword_t push_data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output codeword_t      head_o,
  output logic           empty_o
);

  localparam int unsigned Depth = 2;

  codeword_t  mem_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(Depth));
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // store incoming codewords
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rsge_back.sv */
`default_nettype none
module rsge_back
  import rsge_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire codeword_t         head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CharW-1:0]       char_code_o,
  output logic                   last_char_o
);

  localparam logic [4:0] LastPos = 5'(NumChars - 1);

  codeword_t        cw_q, cw_d;
  logic             active_q, active_d;
  logic [4:0]       pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             slot_free;
  logic [CharW-1:0] cur_char;

  assign slot_free = !out_valid_q || !out_stall_i;

  // character for the current position
  assign cur_char = CharIsDash[pos_q] ? DashCode : sym_char(cw_q.sym[CharSym[pos_q]]);

  // emit one character per free slot; load the next codeword as the last one goes
  always_comb begin
    cw_d        = cw_q;
    active_d    = active_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (active_q) begin
      if (slot_free) begin
        out_valid_d = 1'b1;
        char_d      = cur_char;
        last_d      = (pos_q == LastPos);
        if (pos_q == LastPos) begin
          pos_d = '0;
          if (!empty_i) begin
            pop_o = 1'b1;
            cw_d  = head_i;
          end else begin
            active_d = 1'b0;
          end
        end else begin
          pos_d = pos_q + 5'd1;
        end
      end
    end else begin
      if (slot_free) out_valid_d = 1'b0;
      if (!empty_i) begin
        pop_o    = 1'b1;
        cw_d     = head_i;
        active_d = 1'b1;
        pos_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q   <= cw_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule
`default_nettype wire

/* hw/rtl/rs_gf32_address_encoder.sv */
// Reed-Solomon GF(32) account address encoder. Each 64-bit account word is
// turned into 20 ASCII characters (four groups split by dashes), sent one per
// cycle while out_stall_i is low, with last_char_o high on the twentieth.
// Sustained throughput is set by the one-character-per-cycle output channel.
// The front end runs the parity LFSR one digit per cycle and hands the
// codeword to a two-entry queue, so it accepts the next account while the back
// end is still printing the previous one. The first character passes from the
// front end's LFSR through the queue and the back end's registers.
`default_nettype none
module rs_gf32_address_encoder
  import rsge_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [AcctW-1:0] account_id_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [CharW-1:0]      char_code_o,
  output logic                  last_char_o
);

  logic      push;
  codeword_t push_data;
  logic      full;
  logic      pop;
  codeword_t head;
  logic      empty;

  rsge_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .account_id_i (account_id_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  rsge_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  rsge_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule
`default_nettype wire

/* tb/rsge_address_checker.sv */
`default_nettype none
module rsge_address_checker
  import rsge_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire logic [AcctW-1:0] account_id_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_stall_i,
  input  wire logic [CharW-1:0] char_code_i,
  input  wire logic             last_char_i,
  output int                    mismatches_o,
  output int                    chars_due_o,
  output int                    chars_seen_o
);

  // generator taps and the low bits of x^5 under x^5+x^2+1
  localparam logic [SymW-1:0] GenTap0   = 5'd17;
  localparam logic [SymW-1:0] GenTap1   = 5'd9;
  localparam logic [SymW-1:0] GenTap2   = 5'd6;
  localparam logic [SymW-1:0] GenTap3   = 5'd30;
  localparam logic [SymW-1:0] FieldLow  = 5'b00101;
  localparam int              MaxPrints = 50;

  // codeword symbol shown at each symbol slot, slot 0 in the low bits
  localparam logic [NumSymbols-1:0][SymW-1:0] ShowOrder = {
    5'd11, 5'd10, 5'd9, 5'd8, 5'd12, 5'd16, 5'd15, 5'd14, 5'd13,
    5'd4, 5'd5, 5'd6, 5'd7, 5'd0, 5'd1, 5'd2, 5'd3
  };

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } addr_char_t;

  string      addr_glyphs = "23456789ABCDEFGHJKLMNPQRSTUVWXYZ";
  addr_char_t addr_chars_due [$];
  int         mismatches = 0;
  int         chars_seen = 0;

  // multiply in GF(32) by shift-and-add, reducing on each shift
  function automatic logic [SymW-1:0] gf32_times(input logic [SymW-1:0] a,
                                                 input logic [SymW-1:0] b);
    logic [SymW-1:0] prod;
    logic [SymW-1:0] shifted;
    prod    = '0;
    shifted = a;
    for (int k = 0; k < SymW; k++) begin
      if (b[k]) prod = prod ^ shifted;
      shifted = {shifted[SymW-2:0], 1'b0} ^ (shifted[SymW-1] ? FieldLow : '0);
    end
    return prod;
  endfunction

  // expand one account number into its 20 address characters
  function automatic void predict_address(input logic [AcctW-1:0] acct);
    logic [SymW-1:0] sym [NumSymbols];
    logic [SymW-1:0] par [NumParity];
    logic [SymW-1:0] fb;
    logic [AcctW-1:0] rest;
    addr_char_t      ch;
    byte             g;
    int              pos;
    rest = acct;
    for (int d = 0; d < NumDigits; d++) begin
      sym[d] = rest[SymW-1:0];
      rest   = rest >> SymW;
    end
    for (int p = 0; p < NumParity; p++) par[p] = '0;
    // run the parity LFSR from the top digit down
    for (int d = NumDigits - 1; d >= 0; d--) begin
      fb     = sym[d] ^ par[3];
      par[3] = par[2] ^ gf32_times(GenTap3, fb);
      par[2] = par[1] ^ gf32_times(GenTap2, fb);
      par[1] = par[0] ^ gf32_times(GenTap1, fb);
      par[0] = gf32_times(GenTap0, fb);
    end
    for (int p = 0; p < NumParity; p++) sym[NumDigits + p] = par[p];
    // reorder, map to glyphs and insert a dash after each of the first three groups of four symbols
    pos = 0;
    for (int i = 0; i < NumSymbols; i++) begin
      g       = addr_glyphs[int'(sym[ShowOrder[i]])];
      ch.code = g[CharW-1:0];
      ch.last = (pos == NumChars - 1);
      addr_chars_due.push_back(ch);
      pos++;
      if ((i % 4) == 3 && i < NumDigits) begin
        ch.code = DashCode;
        ch.last = (pos == NumChars - 1);
        addr_chars_due.push_back(ch);
        pos++;
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < MaxPrints) begin
      $display("MISMATCH char %0d: %s got %0d want %0d", chars_seen, what, got, want);
    end
    mismatches++;
  endtask

  // compare each taken character, then queue the characters of each taken word
  always @(posedge clk_i) begin
    addr_char_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (addr_chars_due.size() == 0) begin
          flag_mismatch("unexpected char_code", int'(char_code_i), 0);
        end else begin
          want = addr_chars_due.pop_front();
          if (char_code_i !== want.code) begin
            flag_mismatch("char_code", int'(char_code_i), int'(want.code));
          end
          if (last_char_i !== want.last) begin
            flag_mismatch("last_char", int'(last_char_i), int'(want.last));
          end
        end
        chars_seen++;
      end
      if (in_valid_i && !in_stall_i) predict_address(account_id_i);
    end
    mismatches_o = mismatches;
    chars_due_o  = addr_chars_due.size();
    chars_seen_o = chars_seen;
  end

endmodule
`default_nettype wire

/* tb/rs_gf32_address_encoder_tb.sv */
`default_nettype none
module rs_gf32_address_encoder_tb;
  import rsge_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int RandomItems = 350;
  localparam int TailCycles  = 60;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic [AcctW-1:0] account_id_i = '0;
  logic             out_stall_i  = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [CharW-1:0] char_code_o;
  logic             last_char_o;

  int   mismatches;
  int   chars_due;
  int   chars_seen;
  int   cycles      = 0;
  int   accounts    = 0;
  int   directed    = 0;
  int   stall_left  = 0;
  logic recv_calm   = 1'b0;
  logic send_burst  = 1'b0;
  logic draining    = 1'b0;

  always #1 clk_i = ~clk_i;

  rs_gf32_address_encoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .account_id_i (account_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  rsge_address_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .account_id_i (account_id_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_code_i  (char_code_o),
    .last_char_i  (last_char_o),
    .mismatches_o (mismatches),
    .chars_due_o  (chars_due),
    .chars_seen_o (chars_seen)
  );

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random account: full-width, small, sparse digits or runs of ones
  function automatic logic [AcctW-1:0] random_account();
    logic [AcctW-1:0] v;
    logic [AcctW-1:0] mask;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = v & 64'hF_FFFF;
      1: begin
        mask = '0;
        for (int d = 0; d < NumDigits; d++) begin
          if ($urandom_range(0, 2) == 0) mask = mask | (64'h1F << (SymW * d));
        end
        v = v & mask;
      end
      2: v = ~(v & 64'hFFFF);
      3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stall: random stretches, calm periods with none, quiet while draining
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) recv_calm <= ~recv_calm;
    if (!rst_ni || draining) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= idle_len() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // offer one word after an optional gap and hold it until taken
  task automatic send_account(input logic [AcctW-1:0] acct, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    account_id_i <= acct;
    do @(posedge clk_i); while (in_stall_o);
    accounts++;
  endtask

  function automatic int send_gap();
    int r;
    if (send_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    return idle_len();
  endfunction

  initial begin
    logic [AcctW-1:0] edge_accts [$];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, largest, single bits, patterns and each digit at its maximum
    edge_accts = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h8000_0000_0000_0000,
                   64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                   64'h0000_0000_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF};
    for (int d = 0; d < NumDigits; d++) edge_accts.push_back(64'h1F << (SymW * d));
    foreach (edge_accts[i]) send_account(edge_accts[i], send_gap());
    directed = accounts;

    // random words with bursts of back-to-back traffic
    for (int n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
      send_account(random_account(), send_gap());
    end
    in_valid_i <= 1'b0;

    // drain and watch for stray characters
    @(posedge clk_i);
    while (chars_due != 0) @(posedge clk_i);
    draining <= 1'b1;
    repeat (TailCycles) @(posedge clk_i);

    $display("encoded %0d accounts (%0d directed), %0d characters checked",
             accounts, directed, chars_seen);
    $display("sender gaps and receiver stalls were random, with idle-free stretches");
    if (mismatches == 0 && chars_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d characters never arrived", mismatches, chars_due);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
